FILE: sv/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg
// Types and codes shared by the numeric escape digit decoder.
// ----------------------------------------------------------------------------
package edd_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FEW     = 2'd1,
    ST_BADCODE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FMT_OCT       = 3'd0,
    FMT_HEX_ANY   = 3'd1,
    FMT_HEX_UPPER = 3'd2,
    FMT_HEX_LOWER = 3'd3,
    FMT_HEX_LOCK  = 3'd4
  } fmt_e;

  typedef enum logic [1:0] {
    LOCK_NONE  = 2'd0,
    LOCK_UPPER = 2'd1,
    LOCK_LOWER = 2'd2
  } lock_e;

  // Finished escape handed to the output stage.
  typedef struct packed {
    logic [31:0] value;
    status_e     status;
    logic        not_taken;
    logic        unicode;
  } fin_t;

endpackage

FILE: sv/edd_utf8_emit.sv
// ----------------------------------------------------------------------------
// edd_utf8_emit
// Output stage: encodes a finished escape into up to MaxBytes words and
// hands them out one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module edd_utf8_emit #(
  parameter int MaxBytes = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  edd_pkg::fin_t fin_i,
  output logic        slot_free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic        byte_not_taken_o
);
  import edd_pkg::*;

  localparam int CntW = $clog2(MaxBytes + 1);

  logic [7:0]      byte_q [MaxBytes];
  logic [7:0]      byte_d [MaxBytes];
  logic [CntW-1:0] cnt_q, cnt_d;
  status_e         status_q, status_d;
  logic            nt_q;
  logic [2:0]      n_w;
  logic            pop_w;

  always_comb begin
    logic [31:0] v;
    v = fin_i.value;
    if (v < 32'h80) n_w = 3'd1;
    else if (v < 32'h800) n_w = 3'd2;
    else if (v < 32'h10000) n_w = 3'd3;
    else if (v < 32'h200000) n_w = 3'd4;
    else if (v < 32'h4000000) n_w = 3'd5;
    else if (v < 32'h80000000) n_w = 3'd6;
    else n_w = 3'd7;
  end

  always_comb begin
    logic [31:0] tmp;
    int          sh;
    tmp = '0;
    sh  = 0;
    for (int k = 0; k < MaxBytes; k++) byte_d[k] = 8'h00;
    cnt_d    = CntW'(1);
    status_d = fin_i.status;
    if (fin_i.status != ST_OK) begin
      byte_d[0] = 8'h00;
    end else if (!fin_i.unicode) begin
      byte_d[0] = fin_i.value[7:0];
    end else if (n_w > 3'(MaxBytes)) begin
      status_d = ST_BADCODE;
    end else if (n_w == 3'd1) begin
      byte_d[0] = fin_i.value[7:0];
    end else begin
      cnt_d = CntW'(n_w);
      for (int k = 0; k < MaxBytes; k++) begin
        if (k < int'(n_w)) begin
          sh  = 6 * (int'(n_w) - 1 - k);
          tmp = fin_i.value >> sh;
          if (k == 0) byte_d[k] = 8'(16'hFF00 >> n_w) | tmp[7:0];
          else byte_d[k] = 8'h80 | {2'b00, tmp[5:0]};
        end
      end
    end
  end

  assign pop_w       = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign last_o      = (cnt_q == CntW'(1));
  assign slot_free_o = !out_valid_o || (out_ready_i && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= cnt_d;
    end else if (pop_w) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q   <= byte_d;
      status_q <= status_d;
      nt_q     <= fin_i.not_taken;
    end else if (pop_w) begin
      for (int k = 0; k < MaxBytes - 1; k++) byte_q[k] <= byte_q[k+1];
    end
  end

  assign out_byte_o       = byte_q[0];
  assign status_o         = status_q;
  assign byte_not_taken_o = nt_q;

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_q != ST_OK |-> last_o)
    else $error("error word not last");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_q != ST_OK |-> out_byte_o == 8'h00)
    else $error("error word carries data");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> slot_free_o)
    else $error("load into busy output stage");
`endif

endmodule

FILE: sv/escape_digit_decoder_utf8.sv
// ----------------------------------------------------------------------------
// escape_digit_decoder_utf8
// Numeric escape digit decoder with UTF-8 or single-byte output.
// ----------------------------------------------------------------------------
// A start word loads the initial value, digit limit, format and flags; data
// words are digits shifted into a 32-bit wrapping accumulator; the escape ends
// on a non-digit (byte_not_taken set), on the digit limit, on an end word, or
// at once on a zero limit. A finishing word is held in the output stage,
// which emits one result word per cycle (up to UTF8_MAX_BYTES) while
// out_ready is high; further finishing words wait until the last result word
// of the previous escape is taken, while non-finishing words keep flowing.
module escape_digit_decoder_utf8 #(
  parameter int UTF8_MAX_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] init_value_i,
  input  logic [3:0]  max_digits_i,
  input  logic [2:0]  digit_format_i,
  input  logic        exact_count_i,
  input  logic        emit_unicode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic        byte_not_taken_o
);
  import edd_pkg::*;

  logic [31:0] acc_q, acc_d;
  logic [3:0]  taken_q, taken_d;
  logic [3:0]  limit_q, limit_d;
  fmt_e        fmt_q, fmt_d;
  logic        exact_q, exact_d;
  logic        uni_q, uni_d;
  logic        active_q, active_d;
  lock_e       lock_q, lock_d;

  logic        fin_w, slot_free_w, accept_w;
  fin_t        fin_rec;
  logic        is_dig, up, lo;
  lock_e       lock_dig;
  logic [3:0]  dig_val;
  logic [31:0] acc_new;
  logic [3:0]  taken_new;

  always_comb begin
    logic [7:0] b;
    b        = data_byte_i;
    lock_dig = lock_q;
    up       = b inside {[8'h41:8'h46]};
    lo       = b inside {[8'h61:8'h66]};
    is_dig   = 1'b0;
    dig_val  = b[3:0];
    if (fmt_q == FMT_OCT) begin
      is_dig = b inside {[8'h30:8'h37]};
    end else if (b inside {[8'h30:8'h39]}) begin
      is_dig = 1'b1;
    end else begin
      case (fmt_q)
        FMT_HEX_UPPER: lo = 1'b0;
        FMT_HEX_LOWER: up = 1'b0;
        FMT_HEX_LOCK: begin
          if (lock_q == LOCK_UPPER) lo = 1'b0;
          else if (lock_q == LOCK_LOWER) up = 1'b0;
          else if (up) lock_dig = LOCK_UPPER;
          else if (lo) lock_dig = LOCK_LOWER;
        end
        default: ;
      endcase
      is_dig  = up || lo;
      dig_val = b[3:0] + 4'd9;
    end
  end

  assign acc_new   = (fmt_q == FMT_OCT) ? {acc_q[28:0], 3'b000} + {28'd0, dig_val}
                                        : {acc_q[27:0], 4'b0000} + {28'd0, dig_val};
  assign taken_new = taken_q + 4'd1;

  always_comb begin
    acc_d    = acc_q;
    taken_d  = taken_q;
    limit_d  = limit_q;
    fmt_d    = fmt_q;
    exact_d  = exact_q;
    uni_d    = uni_q;
    active_d = active_q;
    lock_d   = lock_q;
    fin_w    = 1'b0;
    fin_rec.value     = acc_q;
    fin_rec.status    = (exact_q && taken_q != limit_q) ? ST_FEW : ST_OK;
    fin_rec.not_taken = 1'b0;
    fin_rec.unicode   = uni_q;
    case (op_e'(op_i))
      OP_START: begin
        acc_d    = init_value_i;
        taken_d  = 4'd0;
        limit_d  = max_digits_i;
        fmt_d    = fmt_e'(digit_format_i);
        exact_d  = exact_count_i;
        uni_d    = emit_unicode_i;
        lock_d   = LOCK_NONE;
        active_d = 1'b1;
        fin_rec.value   = init_value_i;
        fin_rec.status  = ST_OK;
        fin_rec.unicode = emit_unicode_i;
        if (max_digits_i == 4'd0) begin
          fin_w    = 1'b1;
          active_d = 1'b0;
        end
      end
      OP_DATA: begin
        if (active_q) begin
          if (!is_dig) begin
            fin_w             = 1'b1;
            fin_rec.not_taken = 1'b1;
            active_d          = 1'b0;
          end else begin
            acc_d   = acc_new;
            taken_d = taken_new;
            lock_d  = lock_dig;
            fin_rec.value  = acc_new;
            fin_rec.status = ST_OK;
            if (taken_new == limit_q) begin
              fin_w    = 1'b1;
              active_d = 1'b0;
            end
          end
        end
      end
      OP_END: begin
        if (active_q) begin
          fin_w    = 1'b1;
          active_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = slot_free_w || !fin_w;
  assign accept_w   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      taken_q  <= '0;
      limit_q  <= '0;
      fmt_q    <= FMT_OCT;
      exact_q  <= 1'b0;
      uni_q    <= 1'b0;
      active_q <= 1'b0;
      lock_q   <= LOCK_NONE;
    end else if (accept_w) begin
      acc_q    <= acc_d;
      taken_q  <= taken_d;
      limit_q  <= limit_d;
      fmt_q    <= fmt_d;
      exact_q  <= exact_d;
      uni_q    <= uni_d;
      active_q <= active_d;
      lock_q   <= lock_d;
    end
  end

  edd_utf8_emit #(
    .MaxBytes (UTF8_MAX_BYTES)
  ) u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept_w && fin_w),
    .fin_i            (fin_rec),
    .slot_free_o      (slot_free_w),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .status_o         (status_o),
    .byte_not_taken_o (byte_not_taken_o)
  );

`ifndef SYNTHESIS
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w && fin_w |=> !active_q)
    else $error("escape still active after finish");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w && fin_w |=> out_valid_o)
    else $error("finished escape produced no word");
  a_lock_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q != LOCK_NONE |-> fmt_q == FMT_HEX_LOCK)
    else $error("case lock set outside locking format");
`endif

endmodule

FILE: tb/sv/escape_digit_checker.sv
// ----------------------------------------------------------------------------
// escape_digit_checker
// Watches both channels of the escape digit decoder, predicts every result
// word from the accepted input words and compares them in order.
// ----------------------------------------------------------------------------
module escape_digit_checker #(
  parameter int UTF8_MAX_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] init_value_i,
  input  logic [3:0]  max_digits_i,
  input  logic [2:0]  digit_format_i,
  input  logic        exact_count_i,
  input  logic        emit_unicode_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  input  logic [1:0]  status_i,
  input  logic        byte_not_taken_i,
  output int          fail_count_o,
  output int          pending_o
);
  import edd_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    status_e    status;
    logic       not_taken;
  } char_byte_t;

  char_byte_t  char_bytes_q[$];

  logic [31:0] acc_q;
  logic [3:0]  taken_q;
  logic [3:0]  limit_q;
  logic [2:0]  fmt_q;
  logic        exact_q;
  logic        uni_q;
  logic        active_q;
  lock_e       lock_q;

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    fail_count_o++;
  endtask

  task automatic check_digit(input logic [7:0] b, output logic ok, output logic [3:0] val);
    logic up;
    logic lo;
    up  = (b >= "A" && b <= "F");
    lo  = (b >= "a" && b <= "f");
    ok  = 1'b0;
    val = '0;
    if (fmt_q == FMT_OCT) begin
      if (b >= "0" && b <= "7") begin
        ok  = 1'b1;
        val = 4'(b - "0");
      end
    end else if (b >= "0" && b <= "9") begin
      ok  = 1'b1;
      val = 4'(b - "0");
    end else begin
      if (fmt_q == FMT_HEX_UPPER) begin
        lo = 1'b0;
      end else if (fmt_q == FMT_HEX_LOWER) begin
        up = 1'b0;
      end else if (fmt_q == FMT_HEX_LOCK) begin
        if (lock_q == LOCK_UPPER) lo = 1'b0;
        else if (lock_q == LOCK_LOWER) up = 1'b0;
        else if (up) lock_q = LOCK_UPPER;
        else if (lo) lock_q = LOCK_LOWER;
      end
      if (up) begin
        ok  = 1'b1;
        val = 4'(b - "A" + 8'd10);
      end else if (lo) begin
        ok  = 1'b1;
        val = 4'(b - "a" + 8'd10);
      end
    end
  endtask

  task automatic finish_escape(input logic not_taken);
    logic [31:0] v;
    logic [7:0]  lead;
    char_byte_t  r;
    int          n;
    v = acc_q;
    active_q    = 1'b0;
    r.out_byte  = '0;
    r.last      = 1'b1;
    r.status    = ST_OK;
    r.not_taken = not_taken;
    if (exact_q && taken_q != limit_q) begin
      r.status = ST_FEW;
      char_bytes_q.push_back(r);
    end else if (!uni_q) begin
      r.out_byte = v[7:0];
      char_bytes_q.push_back(r);
    end else begin
      if (v < 32'h80) n = 1;
      else if (v < 32'h800) n = 2;
      else if (v < 32'h1_0000) n = 3;
      else if (v < 32'h20_0000) n = 4;
      else if (v < 32'h400_0000) n = 5;
      else if (v < 32'h8000_0000) n = 6;
      else n = 7;
      if (n > UTF8_MAX_BYTES || n > 6) begin
        r.status = ST_BADCODE;
        char_bytes_q.push_back(r);
      end else if (n == 1) begin
        r.out_byte = v[7:0];
        char_bytes_q.push_back(r);
      end else begin
        for (int k = 0; k < n; k++) begin
          if (k == 0) begin
            lead       = 8'hFF << (8 - n);
            r.out_byte = lead | 8'(v >> (6 * (n - 1)));
          end else begin
            r.out_byte = 8'h80 | 8'((v >> (6 * (n - 1 - k))) & 32'h3F);
          end
          r.last = (k == n - 1);
          char_bytes_q.push_back(r);
        end
      end
    end
  endtask

  task automatic decode_word();
    logic       ok;
    logic [3:0] val;
    case (op_i)
      OP_START: begin
        acc_q    = init_value_i;
        limit_q  = max_digits_i;
        fmt_q    = digit_format_i;
        exact_q  = exact_count_i;
        uni_q    = emit_unicode_i;
        taken_q  = '0;
        lock_q   = LOCK_NONE;
        active_q = 1'b1;
        if (limit_q == 4'd0) finish_escape(1'b0);
      end
      OP_DATA: begin
        if (active_q) begin
          check_digit(data_byte_i, ok, val);
          if (!ok) begin
            finish_escape(1'b1);
          end else begin
            if (fmt_q == FMT_OCT) acc_q = {acc_q[28:0], 3'b000} + 32'(val);
            else acc_q = {acc_q[27:0], 4'b0000} + 32'(val);
            taken_q = taken_q + 4'd1;
            if (taken_q == limit_q) finish_escape(1'b0);
          end
        end
      end
      OP_END: begin
        if (active_q) finish_escape(1'b0);
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    char_byte_t want;
    string      bad;
    if (char_bytes_q.size() == 0) begin
      report_error($sformatf("unexpected word byte=%h last=%b status=%0d not_taken=%b",
                             out_byte_i, last_i, status_i, byte_not_taken_i));
      return;
    end
    want = char_bytes_q.pop_front();
    bad  = "";
    if (out_byte_i !== want.out_byte) bad = {bad, " out_byte"};
    if (last_i !== want.last) bad = {bad, " last"};
    if (status_i !== want.status) bad = {bad, " status"};
    if (byte_not_taken_i !== want.not_taken) bad = {bad, " byte_not_taken"};
    if (bad != "") begin
      report_error($sformatf("mismatch in%s: got %h/%b/%0d/%b want %h/%b/%0d/%b", bad,
                             out_byte_i, last_i, status_i, byte_not_taken_i,
                             want.out_byte, want.last, want.status, want.not_taken));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        = '0;
      taken_q      = '0;
      limit_q      = '0;
      fmt_q        = '0;
      exact_q      = 1'b0;
      uni_q        = 1'b0;
      active_q     = 1'b0;
      lock_q       = LOCK_NONE;
      fail_count_o = 0;
      char_bytes_q.delete();
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) decode_word();
      pending_o <= char_bytes_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_escape_digit_decoder_utf8.sv
// ----------------------------------------------------------------------------
// tb_escape_digit_decoder_utf8
// Drives directed and random escape sequences into the decoder with random
// idling on both channels, a long output stall and a drain pause; the
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_escape_digit_decoder_utf8;
  import edd_pkg::*;

  localparam int          CLK_PERIOD  = 10;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RAND_ITEMS  = 220;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [2:0]  FMT_SPARE   = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [7:0]  data_byte;
  logic [31:0] init_value;
  logic [3:0]  max_digits;
  logic [2:0]  digit_format;
  logic        exact_count;
  logic        emit_unicode;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        last;
  logic [1:0]  status;
  logic        byte_not_taken;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          escape_items = 0;
  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;
  logic        rx_hold = 1'b0;
  logic        hold_go = 1'b0;

  escape_digit_decoder_utf8 dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .op_i             (op),
    .data_byte_i      (data_byte),
    .init_value_i     (init_value),
    .max_digits_i     (max_digits),
    .digit_format_i   (digit_format),
    .exact_count_i    (exact_count),
    .emit_unicode_i   (emit_unicode),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_byte_o       (out_byte),
    .last_o           (last),
    .status_o         (status),
    .byte_not_taken_o (byte_not_taken)
  );

  escape_digit_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .op_i             (op),
    .data_byte_i      (data_byte),
    .init_value_i     (init_value),
    .max_digits_i     (max_digits),
    .digit_format_i   (digit_format),
    .exact_count_i    (exact_count),
    .emit_unicode_i   (emit_unicode),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_byte_i       (out_byte),
    .last_i           (last),
    .status_i         (status),
    .byte_not_taken_i (byte_not_taken),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] w_op, input logic [7:0] b, input logic [31:0] init,
                           input logic [3:0] maxd, input logic [2:0] fmt, input logic exact,
                           input logic uni);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op           <= w_op;
    data_byte    <= b;
    init_value   <= init;
    max_digits   <= maxd;
    digit_format <= fmt;
    exact_count  <= exact;
    emit_unicode <= uni;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_start(input logic [31:0] init, input logic [3:0] maxd,
                            input logic [2:0] fmt, input logic exact, input logic uni);
    send_word(OP_START, 8'($urandom), init, maxd, fmt, exact, uni);
  endtask

  // fields that the block ignores still carry random values
  task automatic send_ctl(input logic [1:0] w_op, input logic [7:0] b);
    send_word(w_op, b, $urandom, 4'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] pick_digit(input logic [2:0] fmt, input logic up);
    int k;
    if (fmt == FMT_OCT) return 8'("0" + $urandom_range(0, 7));
    k = $urandom_range(0, 15);
    if (k < 10) return 8'("0" + k);
    if (fmt == FMT_HEX_UPPER) up = 1'b1;
    else if (fmt == FMT_HEX_LOWER) up = 1'b0;
    else if (fmt != FMT_HEX_LOCK) up = 1'($urandom_range(0, 1));
    return up ? 8'("A" + k - 10) : 8'("a" + k - 10);
  endfunction

  function automatic logic [7:0] pick_stopper(input logic [2:0] fmt);
    case ($urandom_range(0, 3))
      0: return 8'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? "g" : "G";
      2: begin
        if (fmt == FMT_OCT) return 8'("8" + $urandom_range(0, 1));
        if (fmt == FMT_HEX_UPPER) return 8'("a" + $urandom_range(0, 5));
        if (fmt == FMT_HEX_LOWER) return 8'("A" + $urandom_range(0, 5));
        return "x";
      end
      default: return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
    endcase
  endfunction

  task automatic run_escape();
    logic [31:0] init;
    logic [3:0]  maxd;
    logic [2:0]  fmt;
    logic        exact;
    logic        uni;
    logic        up;
    logic [7:0]  b;
    int          n_digits;
    init  = $urandom >> $urandom_range(0, 31);
    maxd  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    fmt   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    exact = 1'($urandom_range(0, 1));
    uni   = ($urandom_range(0, 3) != 0);
    up    = 1'($urandom_range(0, 1));
    send_start(init, maxd, fmt, exact, uni);
    escape_items++;
    if (maxd != 4'd0) begin
      n_digits = ($urandom_range(0, 1) != 0) ? int'(maxd) : $urandom_range(0, maxd);
      for (int i = 0; i < n_digits; i++) begin
        b = ($urandom_range(0, 11) == 0) ? 8'($urandom) : pick_digit(fmt, up);
        send_ctl(OP_DATA, b);
        escape_items++;
      end
      if (n_digits < maxd) begin
        case ($urandom_range(0, 3))
          0: begin
            send_ctl(OP_DATA, pick_stopper(fmt));
            escape_items++;
          end
          1, 2: begin
            send_ctl(OP_END, 8'($urandom));
            escape_items++;
          end
          default: ;
        endcase
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: send_ctl(OP_DATA, 8'($urandom));
        1: send_ctl(OP_END, 8'($urandom));
        default: send_ctl(OP_UNUSED, 8'($urandom));
      endcase
      escape_items++;
    end
  endtask

  initial begin : rx_side
    int gap;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0 || rx_hold) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : rx_stall
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : idle_modes
    forever begin
      repeat ($urandom_range(64, 256)) @(posedge clk);
      tx_quiet <= ($urandom_range(0, 3) == 0);
      rx_quiet <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    op           <= OP_START;
    data_byte    <= '0;
    init_value   <= '0;
    max_digits   <= '0;
    digit_format <= FMT_OCT;
    exact_count  <= 1'b0;
    emit_unicode <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero limit: start emits at once; byte mode, not encodable, widest codes
    send_start(32'h41, 4'd0, FMT_OCT, 1'b0, 1'b1);
    send_start(32'hFFFF_FFFF, 4'd0, FMT_HEX_ANY, 1'b0, 1'b0);
    send_start(32'hFFFF_FFFF, 4'd0, FMT_HEX_ANY, 1'b0, 1'b1);
    send_start(32'h1F_FFFF, 4'd0, FMT_HEX_ANY, 1'b0, 1'b1);
    send_start(32'h20_0000, 4'd0, FMT_HEX_ANY, 1'b0, 1'b1);
    // octal up to the limit, fixed count
    send_start(32'h0, 4'd3, FMT_OCT, 1'b1, 1'b1);
    repeat (3) send_ctl(OP_DATA, "7");
    // hex any case, closed by end of input
    send_start(32'h0, 4'd8, FMT_HEX_ANY, 1'b0, 1'b1);
    send_ctl(OP_DATA, "1");
    send_ctl(OP_DATA, "F");
    send_ctl(OP_DATA, "f");
    send_ctl(OP_END, 8'h00);
    // upper only, lower letter stops it, too few digits
    send_start(32'h0, 4'd4, FMT_HEX_UPPER, 1'b1, 1'b1);
    send_ctl(OP_DATA, "A");
    send_ctl(OP_DATA, "a");
    // lower only, stopped by a zero byte, byte mode
    send_start(32'h0, 4'd2, FMT_HEX_LOWER, 1'b0, 1'b0);
    send_ctl(OP_DATA, 8'h00);
    // case lock: first letter upper, later lower letter rejected
    send_start(32'h0, 4'd4, FMT_HEX_LOCK, 1'b0, 1'b1);
    send_ctl(OP_DATA, "D");
    send_ctl(OP_DATA, "9");
    send_ctl(OP_DATA, "e");
    // restart while active, then a spare format code
    send_start(32'h0, 4'd5, FMT_OCT, 1'b0, 1'b1);
    send_ctl(OP_DATA, "1");
    send_start(32'h0, 4'd1, FMT_SPARE, 1'b0, 1'b1);
    send_ctl(OP_DATA, "a");
    // idle data, idle end, unused op
    send_ctl(OP_DATA, 8'hFF);
    send_ctl(OP_END, 8'hFF);
    send_ctl(OP_UNUSED, 8'h00);

    wait_drained();

    // output held off while short escapes keep coming
    hold_go <= 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_start($urandom >> $urandom_range(0, 31), 4'($urandom_range(0, 1)),
                 3'($urandom_range(0, 4)), 1'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 1) != 0) send_ctl(OP_END, 8'($urandom));

    wait_drained();

    while (escape_items < RAND_ITEMS) run_escape();

    wait_drained();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
